@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the DNS A-record extractor.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ src/dar_pkg.sv @@
// Types and constants of the DNS A-record extractor.
// Depends on nothing; used by dns_a_record_extractor_top.
`default_nettype none

package dar_pkg;

   // Parse phase, one-hot; the last three hold the decided outcomes.
   typedef enum logic [13:0] {
      PH_HEADER = 14'b00_0000_0000_0001,
      PH_QNAME  = 14'b00_0000_0000_0010,
      PH_QLABEL = 14'b00_0000_0000_0100,
      PH_QPTR   = 14'b00_0000_0000_1000,
      PH_QFIXED = 14'b00_0000_0001_0000,
      PH_ANAME  = 14'b00_0000_0010_0000,
      PH_ALABEL = 14'b00_0000_0100_0000,
      PH_APTR   = 14'b00_0000_1000_0000,
      PH_AFIXED = 14'b00_0001_0000_0000,
      PH_ASKIP  = 14'b00_0010_0000_0000,
      PH_ADATA  = 14'b00_0100_0000_0000,
      PH_FOUND  = 14'b00_1000_0000_0000,
      PH_BADLEN = 14'b01_0000_0000_0000,
      PH_NONE   = 14'b10_0000_0000_0000
   } phase_type;

   // Result status codes.
   localparam logic [1:0] STATUS_FOUND  = 2'd0;
   localparam logic [1:0] STATUS_BADLEN = 2'd1;
   localparam logic [1:0] STATUS_NONE   = 2'd2;
   localparam logic [1:0] STATUS_TRUNC  = 2'd3;

   // Protocol constants.
   localparam logic [7:0]  PTR_MASK   = 8'hC0;
   localparam logic [15:0] TYPE_A     = 16'h0001;
   localparam logic [15:0] INET_CLASS = 16'h0001;
   localparam logic [15:0] ADDR_LEN   = 16'd4;

   // Field byte positions.
   localparam logic [3:0] HDR_ANCOUNT_HI = 4'd6;
   localparam logic [3:0] HDR_ANCOUNT_LO = 4'd7;
   localparam logic [3:0] HDR_LAST       = 4'd11;
   localparam logic [3:0] QFIXED_LAST    = 4'd3;
   localparam logic [3:0] AF_TYPE_HI     = 4'd0;
   localparam logic [3:0] AF_TYPE_LO     = 4'd1;
   localparam logic [3:0] AF_CLASS_HI    = 4'd2;
   localparam logic [3:0] AF_CLASS_LO    = 4'd3;
   localparam logic [3:0] AF_DLEN_HI     = 4'd8;
   localparam logic [3:0] AF_DLEN_LO     = 4'd9;
   localparam logic [3:0] ADATA_LAST     = 4'd3;

endpackage

`default_nettype wire

@@ src/dns_a_record_extractor_top.sv @@
// Top level of the DNS A-record extractor: byte parser with a result register.
// Depends on dar_pkg and assert_macros.svh.
//
//   channel | direction | ports                                   | moves
//   req     | in        | req_valid req_stall req_resp_byte        | one message byte
//           |           | req_last_byte                           |
//   rsp     | out       | rsp_valid rsp_stall rsp_status           | one status word
//           |           | rsp_address                             | per message
//
// One byte is taken every cycle unless req is stalled; a byte waits in the input register,
// where the phase logic consumes it. The status word of a message appears on rsp
// at the edge where its final byte leaves the input register. Reset is synchronous
// and returns the parser to the header phase. Only a final byte waiting on a full,
// stalled result register stalls req.
`default_nettype none
`include "assert_macros.svh"

module dns_a_record_extractor_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_resp_byte,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [31:0] rsp_address
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Parser state
   dar_pkg::phase_type phase_ff, phase_in, phase_nxt;
   logic [3:0]  field_idx_ff, field_idx_in, field_idx_nxt;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] answers_ff, answers_in;
   logic [15:0] rec_type_ff, rec_type_in;
   logic [15:0] rec_class_ff, rec_class_in;
   logic [15:0] data_len_ff, data_len_in;
   logic [31:0] accum_ff, accum_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] address_ff, address_in;

   logic        req_accept;
   logic        out_free;
   logic        consume;
   logic        load_rsp;
   logic [15:0] skip_dec;
   logic [15:0] answers_dec;
   logic [15:0] dlen_full;
   logic        is_a_in;

   // Handshake: a non-final byte never waits; a final one waits for the result register
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign consume    = in_valid_ff && (!in_last_ff || out_free);
   assign load_rsp   = consume && in_last_ff;
   assign req_stall  = in_valid_ff && !consume;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept ? 1'b1 : (consume ? 1'b0 : in_valid_ff);

   // Shared arithmetic for the phase logic
   assign skip_dec    = skip_ff - 16'd1;
   assign answers_dec = answers_ff - 16'd1;
   assign dlen_full   = data_len_ff | {8'h00, in_byte_ff};
   assign is_a_in     = (rec_type_ff == dar_pkg::TYPE_A) &&
                        (rec_class_ff == dar_pkg::INET_CLASS);

   // Advance the parser by one byte
   always_comb begin
      phase_nxt     = phase_ff;
      field_idx_nxt = field_idx_ff;
      skip_in       = skip_ff;
      answers_in    = answers_ff;
      rec_type_in   = rec_type_ff;
      rec_class_in  = rec_class_ff;
      data_len_in   = data_len_ff;
      accum_in      = accum_ff;
      if (consume) begin
         unique case (phase_ff)
            dar_pkg::PH_HEADER: begin
               if (field_idx_ff == dar_pkg::HDR_ANCOUNT_HI) begin
                  answers_in = {in_byte_ff, answers_ff[7:0]};
               end else if (field_idx_ff == dar_pkg::HDR_ANCOUNT_LO) begin
                  answers_in = {answers_ff[15:8], in_byte_ff};
               end
               if (field_idx_ff >= dar_pkg::HDR_LAST) begin
                  phase_nxt     = dar_pkg::PH_QNAME;
                  field_idx_nxt = 4'd0;
               end else begin
                  field_idx_nxt = field_idx_ff + 4'd1;
               end
            end
            dar_pkg::PH_QNAME: begin
               if ((in_byte_ff & dar_pkg::PTR_MASK) != 8'h00) begin
                  phase_nxt = dar_pkg::PH_QPTR;
               end else if (in_byte_ff == 8'h00) begin
                  phase_nxt     = dar_pkg::PH_QFIXED;
                  field_idx_nxt = 4'd0;
               end else begin
                  skip_in   = {8'h00, in_byte_ff};
                  phase_nxt = dar_pkg::PH_QLABEL;
               end
            end
            dar_pkg::PH_QLABEL: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_nxt = dar_pkg::PH_QNAME;
               end
            end
            dar_pkg::PH_QPTR: begin
               phase_nxt     = dar_pkg::PH_QFIXED;
               field_idx_nxt = 4'd0;
            end
            dar_pkg::PH_QFIXED: begin
               if (field_idx_ff >= dar_pkg::QFIXED_LAST) begin
                  field_idx_nxt = 4'd0;
                  phase_nxt = (answers_ff == 16'd0) ? dar_pkg::PH_NONE : dar_pkg::PH_ANAME;
               end else begin
                  field_idx_nxt = field_idx_ff + 4'd1;
               end
            end
            dar_pkg::PH_ANAME: begin
               if ((in_byte_ff & dar_pkg::PTR_MASK) != 8'h00) begin
                  phase_nxt = dar_pkg::PH_APTR;
               end else if (in_byte_ff == 8'h00) begin
                  phase_nxt     = dar_pkg::PH_AFIXED;
                  field_idx_nxt = 4'd0;
               end else begin
                  skip_in   = {8'h00, in_byte_ff};
                  phase_nxt = dar_pkg::PH_ALABEL;
               end
            end
            dar_pkg::PH_ALABEL: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_nxt = dar_pkg::PH_ANAME;
               end
            end
            dar_pkg::PH_APTR: begin
               phase_nxt     = dar_pkg::PH_AFIXED;
               field_idx_nxt = 4'd0;
            end
            dar_pkg::PH_AFIXED: begin
               // capture type, class and data length; TTL bytes pass by
               if (field_idx_ff == dar_pkg::AF_TYPE_HI) begin
                  rec_type_in = {in_byte_ff, 8'h00};
               end else if (field_idx_ff == dar_pkg::AF_TYPE_LO) begin
                  rec_type_in = rec_type_ff | {8'h00, in_byte_ff};
               end else if (field_idx_ff == dar_pkg::AF_CLASS_HI) begin
                  rec_class_in = {in_byte_ff, 8'h00};
               end else if (field_idx_ff == dar_pkg::AF_CLASS_LO) begin
                  rec_class_in = rec_class_ff | {8'h00, in_byte_ff};
               end else if (field_idx_ff == dar_pkg::AF_DLEN_HI) begin
                  data_len_in = {in_byte_ff, 8'h00};
               end else if (field_idx_ff == dar_pkg::AF_DLEN_LO) begin
                  data_len_in = dlen_full;
               end
               if (field_idx_ff < dar_pkg::AF_DLEN_LO) begin
                  field_idx_nxt = field_idx_ff + 4'd1;
               end else begin
                  field_idx_nxt = 4'd0;
                  if (is_a_in) begin
                     phase_nxt = (dlen_full == dar_pkg::ADDR_LEN) ? dar_pkg::PH_ADATA
                                                                 : dar_pkg::PH_BADLEN;
                  end else if (dlen_full == 16'd0) begin
                     answers_in = answers_dec;
                     phase_nxt  = (answers_dec == 16'd0) ? dar_pkg::PH_NONE
                                                         : dar_pkg::PH_ANAME;
                  end else begin
                     skip_in   = dlen_full;
                     phase_nxt = dar_pkg::PH_ASKIP;
                  end
               end
            end
            dar_pkg::PH_ASKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  answers_in = answers_dec;
                  phase_nxt  = (answers_dec == 16'd0) ? dar_pkg::PH_NONE : dar_pkg::PH_ANAME;
               end
            end
            dar_pkg::PH_ADATA: begin
               accum_in = {accum_ff[23:0], in_byte_ff};
               if (field_idx_ff >= dar_pkg::ADATA_LAST) begin
                  field_idx_nxt = 4'd0;
                  phase_nxt     = dar_pkg::PH_FOUND;
               end else begin
                  field_idx_nxt = field_idx_ff + 4'd1;
               end
            end
            default: begin
               // decided: drop bytes until the final one
            end
         endcase
      end
   end

   // Rewind to the header phase after the final byte
   always_comb begin
      phase_in     = phase_nxt;
      field_idx_in = field_idx_nxt;
      if (load_rsp) begin
         phase_in     = dar_pkg::PH_HEADER;
         field_idx_in = 4'd0;
      end
   end

   // Form the result word from the phase after this byte
   always_comb begin
      address_in = 32'd0;
      unique case (phase_nxt)
         dar_pkg::PH_FOUND: begin
            status_in  = dar_pkg::STATUS_FOUND;
            address_in = accum_in;
         end
         dar_pkg::PH_BADLEN: status_in = dar_pkg::STATUS_BADLEN;
         dar_pkg::PH_NONE:   status_in = dar_pkg::STATUS_NONE;
         default:            status_in = dar_pkg::STATUS_TRUNC;
      endcase
   end

   // Hold the result until it is taken
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= dar_pkg::PH_HEADER;
         field_idx_ff <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         field_idx_ff <= field_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_resp_byte;
         in_last_ff <= req_last_byte;
      end
      if (load_rsp) begin
         status_ff  <= status_in;
         address_ff <= address_in;
      end
      skip_ff      <= skip_in;
      answers_ff   <= answers_in;
      rec_type_ff  <= rec_type_in;
      rec_class_ff <= rec_class_in;
      data_len_ff  <= data_len_in;
      accum_ff     <= accum_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_address = address_ff;

   // Checks
   `ASSERT_IMPLIES(a_addr_only_found, clock, reset, rsp_valid_ff && (address_ff != 32'd0),
                   status_ff == dar_pkg::STATUS_FOUND)
   `ASSERT_NEXT(a_rewind_after_last, clock, reset, load_rsp,
                (phase_ff == dar_pkg::PH_HEADER) && (field_idx_ff == 4'd0) && rsp_valid_ff)
   `ASSERT_IMPLIES(a_stall_only_final, clock, reset, req_stall,
                   in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall)

endmodule

`default_nettype wire
